FILE: design/mouse_packet_gesture_detector_macros.svh
// Assertion helpers used by the top-level design file.
`ifndef MOUSE_PACKET_GESTURE_DETECTOR_MACROS_SVH
`define MOUSE_PACKET_GESTURE_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPGD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpgd assertion failed");

// Next-cycle implication, checked outside reset.
`define MPGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpgd assertion failed");

`endif

FILE: design/mpgd_pkg.sv
`default_nettype none
package mpgd_pkg;

  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_X_LENGTH   = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MOVE_TOLERANCE = 8'd1;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_UP     = 2'd1;
  localparam logic [1:0] PH_VERTEX = 2'd2;
  localparam logic [1:0] PH_DOWN   = 2'd3;

  localparam int SYNC_BIT = 3;

  typedef struct packed {
    logic              left_button;
    logic              right_button;
    logic              middle_button;
    logic              x_overflow;
    logic              y_overflow;
    logic signed [8:0] delta_x;
    logic signed [8:0] delta_y;
  } packet_t;

  typedef struct packed {
    logic       detected;
    logic [1:0] phase;
  } det_result_t;

endpackage
`default_nettype wire

FILE: design/mpgd_assembler.sv
`default_nettype none
module mpgd_assembler (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  output logic                  pkt_done,
  output mpgd_pkg::packet_t     pkt
);

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  logic [1:0] byte_position;
  logic [1:0] byte_position_next;
  logic [7:0] first_byte;
  logic [7:0] second_byte;

  always_comb begin
    byte_position_next = byte_position;
    case (byte_position)
      POS_FIRST: begin
        if (data_byte[mpgd_pkg::SYNC_BIT]) begin
          byte_position_next = POS_SECOND;
        end
      end
      POS_SECOND: byte_position_next = POS_THIRD;
      POS_THIRD:  byte_position_next = POS_FIRST;
      default:    byte_position_next = POS_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_FIRST;
      first_byte    <= 8'd0;
      second_byte   <= 8'd0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      if (byte_position == POS_FIRST && data_byte[mpgd_pkg::SYNC_BIT]) begin
        first_byte <= data_byte;
      end
      if (byte_position == POS_SECOND) begin
        second_byte <= data_byte;
      end
    end
  end

  assign pkt_done = (byte_position == POS_THIRD);

  always_comb begin
    pkt.left_button   = first_byte[0];
    pkt.right_button  = first_byte[1];
    pkt.middle_button = first_byte[2];
    pkt.x_overflow    = first_byte[6];
    pkt.y_overflow    = first_byte[7];
    pkt.delta_x       = {first_byte[4], second_byte};
    pkt.delta_y       = {first_byte[5], data_byte};
  end

endmodule
`default_nettype wire

FILE: design/mpgd_detector.sv
`default_nettype none
module mpgd_detector #(
  parameter int TRAVEL_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire mpgd_pkg::packet_t pkt,
  input  wire logic [7:0]        min_x_length,
  input  wire logic [7:0]        move_tolerance,
  output logic [1:0]             phase,
  output mpgd_pkg::det_result_t  result
);

  localparam int SW = TRAVEL_WIDTH + 1;

  logic signed [TRAVEL_WIDTH-1:0] x_travel;
  logic signed [TRAVEL_WIDTH-1:0] y_travel;
  logic signed [TRAVEL_WIDTH-1:0] x_travel_next;
  logic signed [TRAVEL_WIDTH-1:0] y_travel_next;
  logic [1:0]                     phase_next;
  logic                           detected;

  logic signed [9:0]  dx10, dy10, tol10, ntol10;
  logic               dx_below, dy_below, dx_above, dy_above;
  logic signed [SW-1:0] xt_w, yt_w, dx_w, dy_w, neg_yt, minx_w, x_sum, y_sum;
  logic signed [TRAVEL_WIDTH-1:0] x_sat, y_sat, dx_t, dy_t;
  localparam logic signed [TRAVEL_WIDTH-1:0] T_MAX = {1'b0, {(TRAVEL_WIDTH-1){1'b1}}};
  localparam logic signed [TRAVEL_WIDTH-1:0] T_MIN = {1'b1, {(TRAVEL_WIDTH-1){1'b0}}};

  always_comb begin
    dx10     = {pkt.delta_x[8], pkt.delta_x};
    dy10     = {pkt.delta_y[8], pkt.delta_y};
    tol10    = $signed({2'b00, move_tolerance});
    ntol10   = -tol10;
    dx_below = dx10 < ntol10;
    dy_below = dy10 < ntol10;
    dx_above = dx10 > tol10;
    dy_above = dy10 > tol10;

    xt_w   = {x_travel[TRAVEL_WIDTH-1], x_travel};
    yt_w   = {y_travel[TRAVEL_WIDTH-1], y_travel};
    dx_w   = {{(SW-9){pkt.delta_x[8]}}, pkt.delta_x};
    dy_w   = {{(SW-9){pkt.delta_y[8]}}, pkt.delta_y};
    dx_t   = {{(TRAVEL_WIDTH-9){pkt.delta_x[8]}}, pkt.delta_x};
    dy_t   = {{(TRAVEL_WIDTH-9){pkt.delta_y[8]}}, pkt.delta_y};
    neg_yt = -yt_w;
    minx_w = $signed({{(SW-8){1'b0}}, min_x_length});

    x_sum = xt_w + dx_w;
    y_sum = yt_w + dy_w;
    if (x_sum[SW-1] != x_sum[SW-2]) begin
      x_sat = x_sum[SW-1] ? T_MIN : T_MAX;
    end else begin
      x_sat = x_sum[TRAVEL_WIDTH-1:0];
    end
    if (y_sum[SW-1] != y_sum[SW-2]) begin
      y_sat = y_sum[SW-1] ? T_MIN : T_MAX;
    end else begin
      y_sat = y_sum[TRAVEL_WIDTH-1:0];
    end
  end

  always_comb begin
    x_travel_next = x_travel;
    y_travel_next = y_travel;
    phase_next    = phase;
    detected      = 1'b0;
    case (phase)
      mpgd_pkg::PH_IDLE: begin
        x_travel_next = '0;
        y_travel_next = '0;
        if (!pkt.middle_button && !pkt.right_button && pkt.left_button &&
            !dx_below && !dy_below) begin
          x_travel_next = dx_t;
          y_travel_next = dy_t;
          phase_next    = mpgd_pkg::PH_UP;
        end
      end
      mpgd_pkg::PH_UP: begin
        if (pkt.middle_button || pkt.right_button) begin
          phase_next = mpgd_pkg::PH_IDLE;
        end else if (!pkt.left_button) begin
          phase_next = (yt_w > xt_w && xt_w >= minx_w) ? mpgd_pkg::PH_VERTEX
                                                       : mpgd_pkg::PH_IDLE;
        end else if (dx_below || dy_below) begin
          phase_next = mpgd_pkg::PH_IDLE;
        end else begin
          x_travel_next = x_sat;
          y_travel_next = y_sat;
        end
      end
      mpgd_pkg::PH_VERTEX: begin
        x_travel_next = '0;
        y_travel_next = '0;
        if (pkt.left_button || pkt.middle_button) begin
          phase_next = mpgd_pkg::PH_IDLE;
        end else if (dx_below || dx_above || dy_below || dy_above) begin
          phase_next = mpgd_pkg::PH_IDLE;
        end else if (pkt.right_button) begin
          phase_next = mpgd_pkg::PH_DOWN;
        end
      end
      default: begin
        if (pkt.middle_button || pkt.left_button) begin
          phase_next = mpgd_pkg::PH_IDLE;
        end else if (!pkt.right_button) begin
          detected   = (neg_yt > xt_w) && (xt_w >= minx_w);
          phase_next = mpgd_pkg::PH_IDLE;
          if (detected) begin
            x_travel_next = '0;
            y_travel_next = '0;
          end
        end else if (dx_below || dy_above) begin
          phase_next = mpgd_pkg::PH_IDLE;
        end else begin
          x_travel_next = x_sat;
          y_travel_next = y_sat;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= mpgd_pkg::PH_IDLE;
      x_travel <= '0;
      y_travel <= '0;
    end else if (advance) begin
      phase    <= phase_next;
      x_travel <= x_travel_next;
      y_travel <= y_travel_next;
    end
  end

  assign result.detected = detected;
  assign result.phase    = phase_next;

endmodule
`default_nettype wire

FILE: design/mouse_packet_gesture_detector.sv
// The result of an input transfer is in the output register in the cycle after it.
// Throughput: one byte per cycle; the output register frees itself in the cycle
// its result is taken, so in_ready stays high under a steady out_ready.
// Reset (rst, synchronous): byte assembly, detector phase, travel sums,
// configuration registers and the output register valid are all cleared.
`default_nettype none
`include "mouse_packet_gesture_detector_macros.svh"
module mouse_packet_gesture_detector #(
  parameter int TRAVEL_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mpgd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [mpgd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [7:0]                           data_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      packet_valid,
  output logic                                      left_button,
  output logic                                      right_button,
  output logic                                      middle_button,
  output logic                                      x_overflow,
  output logic                                      y_overflow,
  output logic signed [8:0]                         delta_x,
  output logic signed [8:0]                         delta_y,
  output logic                                      gesture_detected,
  output logic [1:0]                                gesture_phase
);

  logic [7:0] min_x_length;
  logic [7:0] move_tolerance;
  logic       in_accept;
  logic       pkt_done;
  logic [1:0] phase;
  mpgd_pkg::packet_t     pkt;
  mpgd_pkg::det_result_t det;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x_length   <= 8'd0;
      move_tolerance <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpgd_pkg::CFG_MIN_X_LENGTH:   min_x_length   <= cfg_data;
        mpgd_pkg::CFG_MOVE_TOLERANCE: move_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  mpgd_assembler u_assembler (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_byte (data_byte),
    .pkt_done  (pkt_done),
    .pkt       (pkt)
  );

  mpgd_detector #(
    .TRAVEL_WIDTH (TRAVEL_WIDTH)
  ) u_detector (
    .clk            (clk),
    .rst            (rst),
    .advance        (in_accept && pkt_done),
    .pkt            (pkt),
    .min_x_length   (min_x_length),
    .move_tolerance (move_tolerance),
    .phase          (phase),
    .result         (det)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      packet_valid     <= pkt_done;
      left_button      <= pkt_done && pkt.left_button;
      right_button     <= pkt_done && pkt.right_button;
      middle_button    <= pkt_done && pkt.middle_button;
      x_overflow       <= pkt_done && pkt.x_overflow;
      y_overflow       <= pkt_done && pkt.y_overflow;
      delta_x          <= pkt_done ? pkt.delta_x : 9'sd0;
      delta_y          <= pkt_done ? pkt.delta_y : 9'sd0;
      gesture_detected <= pkt_done && det.detected;
      gesture_phase    <= pkt_done ? det.phase : phase;
    end
  end

  `MPGD_ASSERT_NEXT(a_accept_fills, clk, rst, in_accept, out_valid)
  `MPGD_ASSERT_NOW(a_detect_idle, clk, rst, out_valid && gesture_detected,
                   gesture_phase == mpgd_pkg::PH_IDLE)
  `MPGD_ASSERT_NOW(a_partial_zero, clk, rst, out_valid && !packet_valid,
                   delta_x == 9'sd0 && delta_y == 9'sd0 && !gesture_detected)
  `MPGD_ASSERT_NEXT(a_phase_tracks, clk, rst, in_accept && !pkt_done,
                    gesture_phase == phase)

endmodule
`default_nettype wire
